@@ hdl/tmcd_pkg.sv @@
package tmcd_pkg;

	localparam int TICK_BITS = 24;
	localparam int POS_BITS  = 8;

	typedef logic [7:0]           char_t;
	typedef logic [TICK_BITS-1:0] ticks_t;

	// input item kinds
	localparam logic MODE_BYTE = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	// command characters
	localparam char_t CH_R    = 8'h52;
	localparam char_t CH_L    = 8'h4C;
	localparam char_t CH_G    = 8'h47;
	localparam char_t CH_U    = 8'h55;
	localparam char_t CH_F    = 8'h46;
	localparam char_t CH_B    = 8'h42;
	localparam char_t CH_P    = 8'h50;
	localparam char_t CH_T    = 8'h54;
	localparam char_t CH_ZERO = 8'h30;

	// frame positions (position counts bytes before the current one)
	localparam logic [POS_BITS-1:0] POS_CATEGORY  = 8'd1;
	localparam logic [POS_BITS-1:0] POS_ACTION    = 8'd2;
	localparam logic [POS_BITS-1:0] POS_EVENT     = 8'd3;
	localparam logic [POS_BITS-1:0] POS_MIN_LAST  = 8'd4;
	localparam logic [POS_BITS-1:0] POS_DIGITS    = 8'd5;
	localparam logic [POS_BITS-1:0] POS_DUR_VALID = 8'd6;
	localparam logic [POS_BITS-1:0] POS_MAX       = 8'd255;

	localparam ticks_t MAX_RUN_RESET = 24'd10000;

	typedef struct packed {
		logic in_b;
		logic in_a;
		logic en;
	} wheel_t;

	typedef struct packed {
		wheel_t left;
		wheel_t right;
	} pins_t;

	localparam wheel_t WHEEL_OFF = 3'b000;
	localparam wheel_t WHEEL_FWD = 3'b011;
	localparam wheel_t WHEEL_REV = 3'b101;

	// completed frame handed from the assembler to the drive logic
	typedef struct packed {
		logic   finish;
		char_t  category;
		char_t  action;
		char_t  evt;
		logic   dur_zero;
		ticks_t run_ticks;
	} frame_done_t;

	typedef struct packed {
		pins_t pins;
		logic  run;
	} drive_status_t;

endpackage

@@ hdl/tmcd_if.sv @@
interface tmcd_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] cmd_byte;
	logic       last_byte;

	modport source(output valid, output mode, output cmd_byte, output last_byte, input ready);
	modport sink(input valid, input mode, input cmd_byte, input last_byte, output ready);
endinterface

interface tmcd_out_if;
	logic valid;
	logic ready;
	logic right_enable;
	logic right_in_a;
	logic right_in_b;
	logic left_enable;
	logic left_in_a;
	logic left_in_b;
	logic timed_active;

	modport source(output valid, output right_enable, output right_in_a, output right_in_b,
		output left_enable, output left_in_a, output left_in_b, output timed_active,
		input ready);
	modport sink(input valid, input right_enable, input right_in_a, input right_in_b,
		input left_enable, input left_in_a, input left_in_b, input timed_active,
		output ready);
endinterface

interface tmcd_cfg_if;
	logic        valid;
	logic        ready;
	logic [23:0] data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ hdl/tmcd_frame.sv @@
module tmcd_frame #(
	parameter int ACC_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   proc,
	input  logic                   mode,
	input  tmcd_pkg::char_t        cmd_byte,
	input  logic                   last_byte,
	input  tmcd_pkg::ticks_t       max_run_ticks,
	output tmcd_pkg::frame_done_t  done
);

	localparam int CMP_BITS = (ACC_BITS > tmcd_pkg::TICK_BITS) ? ACC_BITS : tmcd_pkg::TICK_BITS;

	logic [tmcd_pkg::POS_BITS-1:0] pos_q;
	tmcd_pkg::char_t               cat_q;
	tmcd_pkg::char_t               act_q;
	tmcd_pkg::char_t               evt_q;
	logic [ACC_BITS-1:0]           acc_q;
	logic [ACC_BITS-1:0]           acc_next;
	logic [ACC_BITS-1:0]           dur;
	logic [CMP_BITS-1:0]           dur_ext;
	logic [CMP_BITS-1:0]           max_ext;
	logic                          byte_beat;

	assign byte_beat = proc && (mode == tmcd_pkg::MODE_BYTE);

	// acc * 10 + (byte - '0'), wrapping at the accumulator width
	assign acc_next = (acc_q << 3) + (acc_q << 1)
		+ {{(ACC_BITS-8){1'b0}}, cmd_byte}
		- {{(ACC_BITS-8){1'b0}}, tmcd_pkg::CH_ZERO};

	assign dur     = (pos_q >= tmcd_pkg::POS_DUR_VALID) ? acc_q : '0;
	assign dur_ext = CMP_BITS'(dur);
	assign max_ext = CMP_BITS'(max_run_ticks);

	always_comb begin
		done.finish    = byte_beat && last_byte && (pos_q >= tmcd_pkg::POS_MIN_LAST);
		done.category  = cat_q;
		done.action    = act_q;
		done.evt       = evt_q;
		done.dur_zero  = (dur == '0);
		done.run_ticks = (dur_ext > max_ext) ? max_run_ticks
			: dur_ext[tmcd_pkg::TICK_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cat_q <= '0;
			act_q <= '0;
			evt_q <= '0;
			acc_q <= '0;
		end else if (byte_beat) begin
			if (last_byte) begin
				pos_q <= '0;
				cat_q <= '0;
				act_q <= '0;
				evt_q <= '0;
				acc_q <= '0;
			end else begin
				if (pos_q == tmcd_pkg::POS_CATEGORY)
					cat_q <= cmd_byte;
				else if (pos_q == tmcd_pkg::POS_ACTION)
					act_q <= cmd_byte;
				else if (pos_q == tmcd_pkg::POS_EVENT)
					evt_q <= cmd_byte;
				else if (pos_q >= tmcd_pkg::POS_DIGITS)
					acc_q <= acc_next;
				if (pos_q != tmcd_pkg::POS_MAX)
					pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

@@ hdl/tmcd_drive.sv @@
module tmcd_drive (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    proc,
	input  logic                    mode,
	input  tmcd_pkg::frame_done_t   done,
	output tmcd_pkg::drive_status_t status
);

	tmcd_pkg::pins_t  pins_q;
	tmcd_pkg::pins_t  pins_d;
	logic             run_q;
	logic             run_d;
	tmcd_pkg::ticks_t ticks_q;
	tmcd_pkg::ticks_t ticks_d;
	tmcd_pkg::wheel_t wheel_bits;
	logic             wheel_ok;
	tmcd_pkg::wheel_t run_bits;
	logic             run_ok;

	always_comb begin
		wheel_ok   = 1'b1;
		wheel_bits = tmcd_pkg::WHEEL_OFF;
		if (done.evt == tmcd_pkg::CH_U)
			wheel_bits = tmcd_pkg::WHEEL_OFF;
		else if (done.action == tmcd_pkg::CH_F)
			wheel_bits = tmcd_pkg::WHEEL_FWD;
		else if (done.action == tmcd_pkg::CH_B)
			wheel_bits = tmcd_pkg::WHEEL_REV;
		else
			wheel_ok = 1'b0;

		run_ok   = !done.dur_zero;
		run_bits = tmcd_pkg::WHEEL_OFF;
		if (done.evt == tmcd_pkg::CH_F)
			run_bits = tmcd_pkg::WHEEL_FWD;
		else if (done.evt == tmcd_pkg::CH_B)
			run_bits = tmcd_pkg::WHEEL_REV;
		else
			run_ok = 1'b0;
	end

	always_comb begin
		pins_d  = pins_q;
		run_d   = run_q;
		ticks_d = ticks_q;
		if (proc && (mode == tmcd_pkg::MODE_TICK)) begin
			if (run_q) begin
				if (ticks_q <= tmcd_pkg::TICK_BITS'(1)) begin
					pins_d  = '0;
					run_d   = 1'b0;
					ticks_d = '0;
				end else begin
					ticks_d = ticks_q - 1'b1;
				end
			end
		end else if (done.finish) begin
			if (done.category == tmcd_pkg::CH_R) begin
				if (!run_q && wheel_ok)
					pins_d.right = wheel_bits;
			end else if (done.category == tmcd_pkg::CH_L) begin
				if (!run_q && wheel_ok)
					pins_d.left = wheel_bits;
			end else if (done.category == tmcd_pkg::CH_G) begin
				if (done.action == tmcd_pkg::CH_P) begin
					pins_d  = '0;
					run_d   = 1'b0;
					ticks_d = '0;
				end else if (done.action == tmcd_pkg::CH_T && run_ok) begin
					pins_d.left  = run_bits;
					pins_d.right = run_bits;
					run_d        = 1'b1;
					ticks_d      = done.run_ticks;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pins_q  <= '0;
			run_q   <= 1'b0;
			ticks_q <= '0;
		end else begin
			pins_q  <= pins_d;
			run_q   <= run_d;
			ticks_q <= ticks_d;
		end
	end

	assign status.pins = pins_q;
	assign status.run  = run_q;

endmodule

@@ hdl/timed_motor_command_decoder_unit.sv @@
// Decodes framed text commands for two H-bridge wheels and runs timed moves from millisecond
// ticks. Each input beat is either a command byte or a tick; every beat gives exactly one output
// beat with the six pin levels and the timed-run flag as they stand after that beat. A beat is
// registered on entry; the frame assembler and pin/run state are updated as it moves into the
// output register, so its result appears together with the output valid flag and is held until
// taken; one beat per cycle is sustained and the only stall is backpressure on the output
// register. The cap register (reset 10000 ticks) is written over its own port, which is always
// ready, and should be changed only while idle.
module timed_motor_command_decoder_unit #(
	parameter int ACC_BITS = 32
) (
	input logic              clk,
	input logic              arst_n,
	tmcd_in_if.sink          in_ch,
	tmcd_out_if.source       out_ch,
	tmcd_cfg_if.sink         cfg
);

	logic                    valid_s1;
	logic                    mode_s1;
	tmcd_pkg::char_t         byte_s1;
	logic                    last_s1;
	logic                    out_valid_q;
	logic                    adv;
	logic                    proc;
	tmcd_pkg::ticks_t        max_run_q;
	tmcd_pkg::frame_done_t   done;
	tmcd_pkg::drive_status_t status;

	assign adv         = !out_valid_q || out_ch.ready;
	assign proc        = valid_s1 && adv;
	assign in_ch.ready = !valid_s1 || adv;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			max_run_q <= tmcd_pkg::MAX_RUN_RESET;
		else if (cfg.valid)
			max_run_q <= cfg.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ch.ready)
				valid_s1 <= in_ch.valid;
			if (adv)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			mode_s1 <= in_ch.mode;
			byte_s1 <= in_ch.cmd_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	tmcd_frame #(
		.ACC_BITS(ACC_BITS)
	) u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.proc         (proc),
		.mode         (mode_s1),
		.cmd_byte     (byte_s1),
		.last_byte    (last_s1),
		.max_run_ticks(max_run_q),
		.done         (done)
	);

	// pin and run registers double as the result register
	tmcd_drive u_drive (
		.clk   (clk),
		.arst_n(arst_n),
		.proc  (proc),
		.mode  (mode_s1),
		.done  (done),
		.status(status)
	);

	assign out_ch.valid        = out_valid_q;
	assign out_ch.right_enable = status.pins.right.en;
	assign out_ch.right_in_a   = status.pins.right.in_a;
	assign out_ch.right_in_b   = status.pins.right.in_b;
	assign out_ch.left_enable  = status.pins.left.en;
	assign out_ch.left_in_a    = status.pins.left.in_a;
	assign out_ch.left_in_b    = status.pins.left.in_b;
	assign out_ch.timed_active = status.run;

endmodule
